// ----- rtl/square_cost_segment_generator_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic cost segment generator
// Same-cycle and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SQUARE_COST_SEGMENT_GENERATOR_TOP_MACROS_SVH
`define SQUARE_COST_SEGMENT_GENERATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SCSG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/scsg_pkg.sv -----
// ----------------------------------------------------------------------------
// scsg_pkg
// Widths, limits, register indexes and the segment request type shared by
// the front end, the request queue, the cost unit and the top level.
// ----------------------------------------------------------------------------
package scsg_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS);

    localparam int CAP_W   = 16;
    localparam int QSUM_W  = CAP_W + 1;
    localparam int SCALE_W = 24;
    localparam int EXON_W  = 8;
    localparam int COST_W  = 49;
    localparam int PROD_W  = QSUM_W + SCALE_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SCALE_W;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COST_SCALE = 2'd1;

    // One segment request: width, hi+lo (which equals (hi*hi-lo*lo)/width),
    // the divisor, the cost multiplier and the end-of-item mark.
    typedef struct packed {
        logic [CAP_W-1:0]  seg_cap;
        logic [QSUM_W-1:0] qsum;
        logic [CAP_W-1:0]  orig;
        logic [EXON_W-1:0] mult;
        logic              last;
    } seg_desc_t;

endpackage

// ----- rtl/scsg_front.sv -----
// ----------------------------------------------------------------------------
// scsg_front
// Accepts items, drops empty ones and walks the capacity in steps, pushing
// one segment request per cycle into the queue while the queue is not full.
// ----------------------------------------------------------------------------
module scsg_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [scsg_pkg::CAP_W-1:0]     capacity,
    input  logic [scsg_pkg::CAP_W-1:0]     original_capacity,
    input  logic [scsg_pkg::EXON_W-1:0]    num_exons,
    input  logic [scsg_pkg::CAP_W-1:0]     step_size,
    input  logic                           fifo_full,
    output logic                           push,
    output scsg_pkg::seg_desc_t            push_desc
);
    import scsg_pkg::*;

    typedef enum logic {ST_IDLE, ST_WALK} state_t;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SEGMENTS - 1);

    state_t             state_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [CAP_W-1:0]   lo_reg;
    logic [CAP_W-1:0]   orig_reg;
    logic [EXON_W-1:0]  mult_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [CAP_W-1:0]   step_eff;
    logic [QSUM_W-1:0]  hi_step;
    logic               fits;
    logic [CAP_W-1:0]   hi;
    logic               seg_last;
    logic               accept;
    logic [EXON_W-1:0]  mult_in;

    assign step_eff = (step_size == '0) ? CAP_W'(1) : step_size;
    assign hi_step  = {1'b0, lo_reg} + {1'b0, step_eff};
    assign fits     = (hi_step <= {1'b0, cap_reg});
    assign hi       = fits ? hi_step[CAP_W-1:0] : cap_reg;
    assign seg_last = (hi == cap_reg) || (cnt_reg == CNT_LAST);

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign mult_in  = (num_exons > EXON_W'(2)) ? (num_exons - EXON_W'(2)) : EXON_W'(1);

    assign push              = (state_reg == ST_WALK) && !fifo_full;
    assign push_desc.seg_cap = hi - lo_reg;
    assign push_desc.qsum    = {1'b0, hi} + {1'b0, lo_reg};
    assign push_desc.orig    = orig_reg;
    assign push_desc.mult    = mult_reg;
    assign push_desc.last    = seg_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= '0;
            lo_reg    <= '0;
            orig_reg  <= '0;
            mult_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    // drop items that give no segments
                    if (accept && (capacity != '0) && (original_capacity != '0))
                    begin
                        state_reg <= ST_WALK;
                        cap_reg   <= capacity;
                        orig_reg  <= original_capacity;
                        mult_reg  <= mult_in;
                        lo_reg    <= '0;
                        cnt_reg   <= '0;
                    end
                end
                ST_WALK:
                begin
                    if (push)
                    begin
                        lo_reg  <= hi;
                        cnt_reg <= cnt_reg + CNT_W'(1);
                        if (seg_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/scsg_fifo.sv -----
// ----------------------------------------------------------------------------
// scsg_fifo
// Short queue of segment requests between the front end and the cost unit.
// ----------------------------------------------------------------------------
module scsg_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  scsg_pkg::seg_desc_t    push_desc,
    input  logic                   pop,
    output scsg_pkg::seg_desc_t    head_desc,
    output logic                   full,
    output logic                   empty
);
    import scsg_pkg::*;

    seg_desc_t            entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_desc = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (FIFO_AW + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (FIFO_AW + 1)'(1);
            end
        end
    end

endmodule

// ----- rtl/scsg_back.sv -----
// ----------------------------------------------------------------------------
// scsg_back
// Cost unit: multiply by the scale, divide by the original capacity one
// quotient bit per cycle, multiply by the exon factor into the result register.
// ----------------------------------------------------------------------------
module scsg_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  scsg_pkg::seg_desc_t            head_desc,
    input  logic                           fifo_empty,
    output logic                           pop,
    input  logic [scsg_pkg::SCALE_W-1:0]   cost_scale,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [scsg_pkg::CAP_W-1:0]     segment_capacity,
    output logic [scsg_pkg::COST_W-1:0]    segment_cost,
    output logic                           last
);
    import scsg_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

    localparam int DIV_CNT_W = $clog2(PROD_W);
    localparam logic [DIV_CNT_W-1:0] DIV_FIRST = DIV_CNT_W'(PROD_W - 1);

    state_t                 state_reg;
    logic [CAP_W-1:0]       cap_reg;
    logic [CAP_W-1:0]       orig_reg;
    logic [EXON_W-1:0]      mult_reg;
    logic                   last_reg;
    logic [PROD_W-1:0]      quo_reg;
    logic [CAP_W-1:0]       rem_reg;
    logic [DIV_CNT_W-1:0]   bit_cnt_reg;
    logic                   out_valid_reg;
    logic [CAP_W-1:0]       out_cap_reg;
    logic [COST_W-1:0]      out_cost_reg;
    logic                   out_last_reg;

    logic [PROD_W-1:0]      prod;
    logic [CAP_W:0]         trial;
    logic                   ge;
    logic [CAP_W:0]         trial_sub;
    logic [CAP_W-1:0]       rem_new;
    logic [COST_W-1:0]      cost;
    logic                   load;

    assign pop  = (state_reg == ST_IDLE) && !fifo_empty;
    assign prod = PROD_W'(head_desc.qsum) * PROD_W'(cost_scale);

    // restoring division step
    assign trial     = {rem_reg, quo_reg[PROD_W-1]};
    assign ge        = (trial >= {1'b0, orig_reg});
    assign trial_sub = trial - {1'b0, orig_reg};
    assign rem_new   = ge ? trial_sub[CAP_W-1:0] : trial[CAP_W-1:0];

    assign cost = COST_W'(quo_reg) * COST_W'(mult_reg);
    assign load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    assign out_valid        = out_valid_reg;
    assign segment_capacity = out_cap_reg;
    assign segment_cost     = out_cost_reg;
    assign last             = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= '0;
            orig_reg      <= '0;
            mult_reg      <= '0;
            last_reg      <= 1'b0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_cap_reg   <= '0;
            out_cost_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cap_reg     <= head_desc.seg_cap;
                        orig_reg    <= head_desc.orig;
                        mult_reg    <= head_desc.mult;
                        last_reg    <= head_desc.last;
                        quo_reg     <= prod;
                        rem_reg     <= '0;
                        bit_cnt_reg <= DIV_FIRST;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg     <= rem_new;
                    quo_reg     <= {quo_reg[PROD_W-2:0], ge};
                    bit_cnt_reg <= bit_cnt_reg - DIV_CNT_W'(1);
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    // hold until the result register is free
                    if (load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (load)
            begin
                out_valid_reg <= 1'b1;
                out_cap_reg   <= cap_reg;
                out_cost_reg  <= cost;
                out_last_reg  <= last_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/square_cost_segment_generator_top.sv -----
// ----------------------------------------------------------------------------
// square_cost_segment_generator_top
// Each segment passes the front end, the request queue, the divider and
// the result register. The cost unit takes one segment at a time through
// its one-bit-per-cycle divider (41 quotient bits) before taking the next.
// Items with zero capacity or original capacity are dropped at acceptance.
// Reset: asynchronous, active low; registers return to step 1, scale 1.
// ----------------------------------------------------------------------------
module square_cost_segment_generator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [scsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scsg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [scsg_pkg::CAP_W-1:0]         capacity,
    input  logic [scsg_pkg::CAP_W-1:0]         original_capacity,
    input  logic [scsg_pkg::EXON_W-1:0]        num_exons,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [scsg_pkg::CAP_W-1:0]         segment_capacity,
    output logic [scsg_pkg::COST_W-1:0]        segment_cost,
    output logic                               last
);
    import scsg_pkg::*;

    logic [CAP_W-1:0]   step_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;
    seg_desc_t          push_desc;
    seg_desc_t          head_desc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= CAP_W'(1);
            scale_reg <= SCALE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STEP_SIZE:  step_reg  <= cfg_data[CAP_W-1:0];
                REG_COST_SCALE: scale_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    scsg_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .capacity          (capacity),
        .original_capacity (original_capacity),
        .num_exons         (num_exons),
        .step_size         (step_reg),
        .fifo_full         (fifo_full),
        .push              (push),
        .push_desc         (push_desc)
    );

    scsg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    scsg_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_desc        (head_desc),
        .fifo_empty       (fifo_empty),
        .pop              (pop),
        .cost_scale       (scale_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .segment_capacity (segment_capacity),
        .segment_cost     (segment_cost),
        .last             (last)
    );

endmodule

// ----- rtl/scsg_checker.sv -----
// ----------------------------------------------------------------------------
// scsg_checker
// Port-level checks on the segment generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "square_cost_segment_generator_top_macros.svh"

module scsg_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [scsg_pkg::CAP_W-1:0]     capacity,
    input  logic [scsg_pkg::CAP_W-1:0]     original_capacity,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [scsg_pkg::CAP_W-1:0]     segment_capacity,
    input  logic [scsg_pkg::COST_W-1:0]    segment_cost,
    input  logic                           last
);
    import scsg_pkg::*;

    // a stalled result keeps its payload
    `SCSG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(segment_capacity) && $stable(segment_cost) && $stable(last), "stalled result changed")

    // every segment has a nonzero width
    `SCSG_ASSERT_NOW(a_seg_nonzero, out_valid, segment_capacity != '0, "zero-width segment")

    // a real item makes the front busy in the cycle after it is taken
    `SCSG_ASSERT_NEXT(a_busy_after, in_valid && !in_stall && (capacity != '0) && (original_capacity != '0), in_stall, "front took no time for an item")

    // an empty item is dropped at once
    `SCSG_ASSERT_NEXT(a_drop_empty, in_valid && !in_stall && ((capacity == '0) || (original_capacity == '0)), !in_stall, "empty item left the front busy")

endmodule

bind square_cost_segment_generator_top scsg_checker u_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the quadratic cost segment generator
// Sends capacity requests under several step and scale settings and idling
// patterns, predicts every segment locally and checks each one in order.
// ----------------------------------------------------------------------------
module testbench;
    import scsg_pkg::*;

    localparam longint unsigned COST_LIMIT = (64'd1 << COST_W) - 64'd1;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_PRINTED  = 20;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    typedef struct packed {
        logic [CAP_W-1:0]  cap;
        logic [CAP_W-1:0]  orig;
        logic [EXON_W-1:0] exons;
    } cap_request_t;

    typedef struct packed {
        logic [CAP_W-1:0]  cap;
        logic [COST_W-1:0] cost;
        logic              last;
    } segment_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CAP_W-1:0]      capacity = '0;
    logic [CAP_W-1:0]      original_capacity = '0;
    logic [EXON_W-1:0]     num_exons = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CAP_W-1:0]      segment_capacity;
    logic [COST_W-1:0]     segment_cost;
    logic                  last;

    cap_request_t requests_pending[$];
    segment_t     segments_due[$];
    cap_request_t next_request;
    logic         in_fire = 1'b0;

    logic [CAP_W-1:0]   step_setting = 16'd1;
    logic [SCALE_W-1:0] scale_setting = 24'd1;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int error_count = 0;
    int requests_taken = 0;
    int segments_checked = 0;
    int clipped_requests = 0;
    int empty_requests = 0;

    square_cost_segment_generator_top uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .capacity          (capacity),
        .original_capacity (original_capacity),
        .num_exons         (num_exons),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .segment_capacity  (segment_capacity),
        .segment_cost      (segment_cost),
        .last              (last)
    );

    always #5 clk = ~clk;

    // Work out the segments one request must produce and queue them.
    function automatic void predict_segments(cap_request_t req);
        longint unsigned step_eff, mult, full, done_cap, left, total, n;
        longint unsigned lo, hi, q, v;
        segment_t seg;
        step_eff = (step_setting == 0) ? 1 : step_setting;
        mult = (req.exons > 2) ? req.exons - 2 : 1;
        if (req.cap == 0 || req.orig == 0)
        begin
            empty_requests++;
            return;
        end
        full = req.cap / step_eff;
        done_cap = full * step_eff;
        left = req.cap - done_cap;
        total = full + ((left != 0) ? 1 : 0);
        n = (total < MAX_SEGMENTS) ? total : MAX_SEGMENTS;
        if (total > MAX_SEGMENTS)
            clipped_requests++;
        for (longint unsigned k = 0; k < n; k++)
        begin
            if (k < full)
            begin
                lo = k * step_eff;
                hi = lo + step_eff;
            end
            else
            begin
                lo = done_cap;
                hi = req.cap;
            end
            q = (hi * hi - lo * lo) / (hi - lo);
            v = (q * scale_setting / req.orig) * mult;
            if (v > COST_LIMIT)
                v = COST_LIMIT;
            seg.cap = CAP_W'(hi - lo);
            seg.cost = COST_W'(v);
            seg.last = (k + 1 == n);
            segments_due = {segments_due, seg};
        end
    endfunction

    // Request driver: hold the payload until taken, idle at random.
    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (requests_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_request = requests_pending.pop_front();
                capacity <= next_request.cap;
                original_capacity <= next_request.orig;
                num_exons <= next_request.exons;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Request and segment monitor.
    always @(posedge clk)
    begin
        in_fire <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            requests_taken++;
            predict_segments('{capacity, original_capacity, num_exons});
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (segments_due.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_PRINTED)
                    $display("%0t: unexpected segment cap %0d cost %0d last %0d",
                             $time, segment_capacity, segment_cost, last);
            end
            else
            begin
                segment_t want;
                want = segments_due.pop_front();
                segments_checked++;
                if (want.cap !== segment_capacity || want.cost !== segment_cost
                    || want.last !== last)
                begin
                    error_count++;
                    if (error_count <= MAX_PRINTED)
                        $display({"%0t: segment mismatch: expected cap %0d cost %0d",
                                  " last %0d, got cap %0d cost %0d last %0d"},
                                 $time, want.cap, want.cost, want.last,
                                 segment_capacity, segment_cost, last);
                end
            end
        end
    end

    task automatic set_idling(idling_t mode);
        send_idle_pct = (mode == IDLE_SENDER) ? 55 : (mode == IDLE_BOTH) ? 31 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 55 : (mode == IDLE_BOTH) ? 31 : 0;
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_STEP_SIZE)
            step_setting = value[CAP_W-1:0];
        else if (idx == REG_COST_SCALE)
            scale_setting = value[SCALE_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_request(int cap, int orig, int exons);
        cap_request_t req;
        req = '{CAP_W'(cap), CAP_W'(orig), EXON_W'(exons)};
        requests_pending = {requests_pending, req};
    endtask

    // Mostly short well-formed requests sized to the step, with some
    // dropped requests and some full-range capacities mixed in.
    task automatic queue_random(int count);
        int kind, n;
        longint eff, cap, orig;
        for (int i = 0; i < count; i++)
        begin
            eff = (step_setting == 0) ? 1 : step_setting;
            kind = $urandom_range(0, 9);
            case ($urandom_range(0, 3))
                0: orig = $urandom_range(1, 15);
                1: orig = 65535 - $urandom_range(0, 15);
                default: orig = $urandom_range(0, 65535);
            endcase
            if (kind == 0)
                orig = 0;
            if (kind == 1)
                cap = 0;
            else if (kind == 2)
                cap = $urandom_range(0, 65535);
            else
            begin
                n = $urandom_range(1, 8);
                cap = (n - 1) * eff + $urandom_range(1, eff);
                if (cap > 65535)
                    cap = 65535;
            end
            push_request(cap, orig, $urandom_range(0, 255));
        end
    endtask

    // Wait until every request is taken and every segment has come back.
    task automatic drain();
        while (requests_pending.size() != 0 || in_valid || segments_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: unit step and scale.
        set_idling(IDLE_NONE);
        push_request(1, 1, 0);
        push_request(2, 1, 3);
        push_request(3, 65535, 2);
        push_request(65535, 65535, 255);
        push_request(0, 5, 5);
        push_request(5, 0, 5);
        drain();

        // Boundaries around full steps and the segment limit.
        write_register(REG_STEP_SIZE, 24'd100);
        write_register(REG_COST_SCALE, 24'hFFFFFF);
        push_request(1, 1, 1);
        push_request(100, 7, 4);
        push_request(101, 65535, 255);
        push_request(6350, 3, 200);
        push_request(6400, 1, 255);
        push_request(6499, 2, 10);
        push_request(65535, 1, 255);
        push_request(0, 0, 0);
        push_request(0, 65535, 255);
        push_request(65535, 0, 255);
        push_request(43690, 21845, 170);
        push_request(21845, 43690, 85);
        drain();

        set_idling(IDLE_SENDER);
        write_register(REG_STEP_SIZE, 24'd65535);
        push_request(65535, 1, 255);
        push_request(65534, 1, 255);
        queue_random(24);
        drain();

        // Step of zero behaves as a step of one.
        set_idling(IDLE_RECEIVER);
        write_register(REG_STEP_SIZE, 24'd0);
        write_register(REG_COST_SCALE, CFG_DATA_W'($urandom_range(1, 24'hFFFFFF)));
        queue_random(24);
        drain();

        set_idling(IDLE_BOTH);
        write_register(REG_STEP_SIZE, CFG_DATA_W'($urandom_range(1, 2000)));
        write_register(REG_COST_SCALE, CFG_DATA_W'($urandom_range(1, 24'hFFFFFF)));
        queue_random(24);
        drain();

        set_idling(IDLE_NONE);
        write_register(REG_STEP_SIZE, CFG_DATA_W'($urandom_range(2, 300)));
        write_register(REG_COST_SCALE, CFG_DATA_W'($urandom_range(1, 4095)));
        queue_random(24);
        drain();

        set_idling(IDLE_SENDER);
        write_register(REG_STEP_SIZE, CFG_DATA_W'($urandom_range(1, 65535)));
        write_register(REG_COST_SCALE, 24'd1);
        queue_random(24);
        drain();

        $display("Checked %0d segments from %0d requests over seven settings.",
                 segments_checked, requests_taken);
        $display("%0d requests hit the segment limit, %0d produced no segments.",
                 clipped_requests, empty_requests);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(60_000_000);
        $display("Timeout with %0d segments still expected.", segments_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/scsg_pkg.sv
rtl/scsg_front.sv
rtl/scsg_fifo.sv
rtl/scsg_back.sv
rtl/square_cost_segment_generator_top.sv
rtl/scsg_checker.sv
tb/sv/testbench.sv
